FILE: hw/rtl/radar_tlv_frame_parser_macros.svh
// assertion macros for the radar tlv frame parser
// no dependencies; included by the top level only
`ifndef RADAR_TLV_FRAME_PARSER_MACROS_SVH
`define RADAR_TLV_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define RTFP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTFP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rtfp_pkg.sv
// shared types and constants of the radar tlv frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package rtfp_pkg;

	localparam logic [63:0] MAGIC_WORD = 64'h0201_0403_0605_0807;
	localparam logic [31:0] MAGIC_BYTES = 32'd8;

	localparam logic [31:0] HDR_STORE_BYTES = 32'd40;
	localparam logic [31:0] PKT_LEN_POS = 32'd15;
	localparam logic [31:0] COUNT_POS = 32'd31;
	localparam logic [31:0] TLV_KIND_POS = 32'd3;
	localparam logic [31:0] TLV_HEAD_LAST = 32'd7;

	localparam logic [31:0] TLV_POINTS = 32'd1;
	localparam logic [31:0] TLV_SNR = 32'd7;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_SNR = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_COUNT = 2'd1;
	localparam logic [1:0] ERR_SUBFRAME = 2'd2;
	localparam logic [1:0] ERR_TOO_MANY = 2'd3;

	localparam logic [7:0] MAX_SUBFRAME_RESET = 8'd3;

	// compact result; the back end expands it to the output fields
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] index;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		logic [1:0]  err;
		logic        last;
	} rec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/radar_tlv_frame_parser.sv
// top level of the radar tlv frame parser: front end, result queue, back end
// depends on rtfp_pkg, rtfp_front, rtfp_queue, rtfp_back and the macros header
//
// channel   direction  handshake          payload
// input     in         push / full        data_byte
// result    out        empty / pop        kind .. last
// config    in         cfg_we             cfg_data (max_subframe)
//
// one byte is taken every cycle while full is low; each byte is parsed by combinational logic into registered state
// a result passes through the queue, then the output register, before it shows on the ports;
// QUEUE_DEPTH results queue behind the one shown before full rises
// arst_n returns the parser to the magic hunt and empties queue and output register
// max_subframe resets to 3; no clearing pass is needed after reset
`default_nettype none

module radar_tlv_frame_parser import rtfp_pkg::*; #(
	parameter int HEADER_BYTES = 40,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [15:0]      object_index,
	output logic [31:0]      x_word,
	output logic [31:0]      y_word,
	output logic [31:0]      z_word,
	output logic [31:0]      v_word,
	output logic [15:0]      snr,
	output logic [15:0]      noise,
	output logic [1:0]       error_code,
	output logic             last
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0]    max_subframe_q;
	logic          in_valid;
	logic          q_push;
	rec_t          q_push_rec;
	logic          q_pop;
	rec_t          q_head;
	logic [CW-1:0] q_count;

	assign full = q_count == CW'(QUEUE_DEPTH);
	assign in_valid = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_subframe_q <= MAX_SUBFRAME_RESET;
		end else if (cfg_we) begin
			max_subframe_q <= cfg_data;
		end
	end

	rtfp_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.data_byte(data_byte),
		.max_subframe(max_subframe_q),
		.emit(q_push),
		.rec(q_push_rec)
	);

	rtfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_rec(q_push_rec),
		.pop(q_pop),
		.head(q_head),
		.count(q_count)
	);

	rtfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.head_valid(q_count != '0),
		.pop(pop),
		.take(q_pop),
		.empty(empty),
		.kind(kind),
		.object_index(object_index),
		.x_word(x_word),
		.y_word(y_word),
		.z_word(z_word),
		.v_word(v_word),
		.snr(snr),
		.noise(noise),
		.error_code(error_code),
		.last(last)
	);

`include "radar_tlv_frame_parser_macros.svh"

	`RTFP_ASSERT_IMPL(a_reject_fields, clk, arst_n, !empty && kind == KIND_REJECT, last && error_code != ERR_NONE, "rejection without last or error code")
	`RTFP_ASSERT_IMPL(a_data_no_error, clk, arst_n, !empty && kind != KIND_REJECT, error_code == ERR_NONE, "point or record carries an error code")
	`RTFP_ASSERT_NEXT(a_queue_fill, clk, arst_n, q_push && !q_pop, q_count == $past(q_count) + 1'b1, "queue count did not follow a request")

endmodule

`default_nettype wire

FILE: hw/rtl/rtfp_front.sv
// byte parser: magic hunt, header, tlv walk; emits compact results
// depends on rtfp_pkg
`default_nettype none

module rtfp_front import rtfp_pkg::*; #(
	parameter int HEADER_BYTES = 40
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] max_subframe,
	output logic            emit,
	output rec_t            rec
);

	typedef enum logic [5:0] {
		PH_HUNT     = 6'b000001,
		PH_HEADER   = 6'b000010,
		PH_TLV_HEAD = 6'b000100,
		PH_POINTS   = 6'b001000,
		PH_SKIP     = 6'b010000,
		PH_SNR      = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [63:0] magic_q, magic_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] hw_q, hw_d;
	logic [31:0] pkt_len_q, pkt_len_d;
	logic [31:0] cnt_q, cnt_d;
	logic [15:0] total_q, total_d;
	logic [15:0] obj_q, obj_d;
	logic        kind1_q, kind1_d;
	logic        kind7_q, kind7_d;
	logic [31:0] tlv_len_q, tlv_len_d;
	logic        second_q, second_d;
	logic [31:0] x_q, x_d;
	logic [31:0] y_q, y_d;
	logic [31:0] z_q, z_d;

	logic [31:0] hw_shift;
	logic [31:0] pos_inc;
	logic [63:0] magic_shift;
	logic [16:0] obj_next;
	logic        obj_last;
	logic [31:0] sub_word;
	logic [1:0]  hdr_err;

	assign hw_shift = {data_byte, hw_q[31:8]};
	assign pos_inc = pos_q + 32'd1;
	assign magic_shift = {magic_q[55:0], data_byte};
	assign obj_next = {1'b0, obj_q} + 17'd1;
	assign obj_last = obj_next == {1'b0, total_q};
	assign sub_word = (pos_q < HDR_STORE_BYTES) ? hw_shift : hw_q;

	always_comb begin
		if (cnt_q == 32'd0 || cnt_q[31]) begin
			hdr_err = ERR_COUNT;
		end else if (!sub_word[31] && (sub_word[30:8] != 23'd0 || sub_word[7:0] > max_subframe)) begin
			hdr_err = ERR_SUBFRAME;
		end else if (cnt_q[31:16] != 16'd0) begin
			hdr_err = ERR_TOO_MANY;
		end else begin
			hdr_err = ERR_NONE;
		end
	end

	always_comb begin
		phase_d = phase_q;
		magic_d = magic_q;
		pos_d = pos_q;
		hw_d = hw_q;
		pkt_len_d = pkt_len_q;
		cnt_d = cnt_q;
		total_d = total_q;
		obj_d = obj_q;
		kind1_d = kind1_q;
		kind7_d = kind7_q;
		tlv_len_d = tlv_len_q;
		second_d = second_q;
		x_d = x_q;
		y_d = y_q;
		z_d = z_q;
		emit = 1'b0;
		rec = '0;

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q < HDR_STORE_BYTES) begin
					hw_d = hw_shift;
				end
				if (pos_q == PKT_LEN_POS) begin
					pkt_len_d = hw_shift;
				end
				if (pos_q == COUNT_POS) begin
					cnt_d = hw_shift;
				end
				pos_d = pos_inc;
				if (pos_inc >= 32'(HEADER_BYTES)) begin
					if (hdr_err != ERR_NONE) begin
						emit = 1'b1;
						rec.kind = KIND_REJECT;
						rec.err = hdr_err;
						rec.last = 1'b1;
						phase_d = PH_HUNT;
						magic_d = '0;
						pos_d = '0;
					end else begin
						total_d = cnt_q[15:0];
						phase_d = PH_TLV_HEAD;
						second_d = 1'b0;
						pos_d = '0;
						hw_d = '0;
					end
				end
			end
			PH_TLV_HEAD: begin
				hw_d = hw_shift;
				if (pos_q == TLV_KIND_POS) begin
					kind1_d = hw_shift == TLV_POINTS;
					kind7_d = hw_shift == TLV_SNR;
				end
				pos_d = pos_inc;
				if (pos_q >= TLV_HEAD_LAST) begin
					tlv_len_d = hw_shift;
					pos_d = '0;
					obj_d = '0;
					hw_d = '0;
					if (!second_q) begin
						if (kind1_q && hw_shift < pkt_len_q) begin
							phase_d = PH_POINTS;
						end else if (hw_shift == 32'd0) begin
							phase_d = PH_TLV_HEAD;
							second_d = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end else if (kind7_q) begin
						phase_d = PH_SNR;
					end else begin
						phase_d = PH_HUNT;
						magic_d = '0;
					end
				end
			end
			PH_POINTS: begin
				hw_d = hw_shift;
				pos_d = pos_inc;
				if (pos_q[1:0] == 2'b11) begin
					case (pos_q[3:2])
						2'd0: x_d = hw_shift;
						2'd1: y_d = hw_shift;
						2'd2: z_d = hw_shift;
						default: ;
					endcase
				end
				if (pos_q[3:0] == 4'hf) begin
					emit = 1'b1;
					rec.kind = KIND_POINT;
					rec.index = obj_q;
					rec.w0 = x_q;
					rec.w1 = y_q;
					rec.w2 = z_q;
					rec.w3 = hw_shift;
					rec.last = obj_last;
					obj_d = obj_next[15:0];
					if (obj_last) begin
						if (pos_inc >= tlv_len_q) begin
							phase_d = PH_TLV_HEAD;
							second_d = 1'b1;
							pos_d = '0;
							hw_d = '0;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				pos_d = pos_inc;
				if (pos_inc >= tlv_len_q) begin
					phase_d = PH_TLV_HEAD;
					second_d = 1'b1;
					pos_d = '0;
					hw_d = '0;
				end
			end
			PH_SNR: begin
				hw_d = hw_shift;
				pos_d = pos_inc;
				if (pos_q[1:0] == 2'b11) begin
					emit = 1'b1;
					rec.kind = KIND_SNR;
					rec.index = obj_q;
					rec.w3 = hw_shift;
					rec.last = obj_last;
					obj_d = obj_next[15:0];
					if (obj_last) begin
						phase_d = PH_HUNT;
						magic_d = '0;
						pos_d = '0;
					end
				end
			end
			PH_HUNT: begin
				magic_d = magic_shift;
				if (magic_shift == MAGIC_WORD) begin
					phase_d = PH_HEADER;
					pos_d = MAGIC_BYTES;
					hw_d = '0;
				end
			end
			default: begin
				magic_d = magic_shift;
				phase_d = PH_HUNT;
				if (magic_shift == MAGIC_WORD) begin
					phase_d = PH_HEADER;
					pos_d = MAGIC_BYTES;
					hw_d = '0;
				end
			end
		endcase

		if (!in_valid) begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			magic_q <= '0;
			pos_q <= '0;
			obj_q <= '0;
			second_q <= 1'b0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			magic_q <= magic_d;
			pos_q <= pos_d;
			obj_q <= obj_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			hw_q <= hw_d;
			pkt_len_q <= pkt_len_d;
			cnt_q <= cnt_d;
			total_q <= total_d;
			kind1_q <= kind1_d;
			kind7_q <= kind7_d;
			tlv_len_q <= tlv_len_d;
			x_q <= x_d;
			y_q <= y_d;
			z_q <= z_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rtfp_queue.sv
// result queue between parser front end and output back end
// depends on rtfp_pkg
`default_nettype none

module rtfp_queue import rtfp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire rec_t                         push_rec,
	input  wire logic                         pop,
	output rec_t                              head,
	output logic [$clog2(DEPTH + 1) - 1:0]    count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		logic [AW-1:0] n;
		if (p == AW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	assign head = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rtfp_back.sv
// output stage: takes the queue head, expands it to result fields
// depends on rtfp_pkg
`default_nettype none

module rtfp_back import rtfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rec_t        head,
	input  wire logic        head_valid,
	input  wire logic        pop,
	output logic             take,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [15:0]      object_index,
	output logic [31:0]      x_word,
	output logic [31:0]      y_word,
	output logic [31:0]      z_word,
	output logic [31:0]      v_word,
	output logic [15:0]      snr,
	output logic [15:0]      noise,
	output logic [1:0]       error_code,
	output logic             last
);

	logic valid_q;
	logic is_point;
	logic is_snr;

	assign take = head_valid && (!valid_q || pop);
	assign empty = !valid_q;
	assign is_point = head.kind == KIND_POINT;
	assign is_snr = head.kind == KIND_SNR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind <= head.kind;
			object_index <= head.index;
			x_word <= is_point ? head.w0 : 32'd0;
			y_word <= is_point ? head.w1 : 32'd0;
			z_word <= is_point ? head.w2 : 32'd0;
			v_word <= is_point ? head.w3 : 32'd0;
			snr <= is_snr ? head.w3[15:0] : 16'd0;
			noise <= is_snr ? head.w3[31:16] : 16'd0;
			error_code <= head.err;
			last <= head.last;
		end
	end

endmodule

`default_nettype wire

FILE: dv/tlv_result_checker.sv
`timescale 1ns / 1ps
// result checker for the radar tlv frame parser: follows the byte, result and register
// channels, predicts every result from the accepted bytes and compares them in order
// depends on rtfp_pkg; instantiated beside the block by the testbench top
module tlv_result_checker import rtfp_pkg::*; #(
	parameter int HEADER_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [15:0] object_index,
	input  logic [31:0] x_word,
	input  logic [31:0] y_word,
	input  logic [31:0] z_word,
	input  logic [31:0] v_word,
	input  logic [15:0] snr,
	input  logic [15:0] noise,
	input  logic [1:0]  error_code,
	input  logic        last,
	output int          fail_count,
	output int          outstanding,
	output int          byte_total,
	output int          point_total,
	output int          record_total,
	output int          reject_total
);

	typedef enum logic [3:0] {
		P_HUNT,
		P_HEADER,
		P_TLV_HEAD,
		P_POINTS,
		P_SKIP,
		P_SNR
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] index;
		logic [31:0] x_w;
		logic [31:0] y_w;
		logic [31:0] z_w;
		logic [31:0] v_w;
		logic [15:0] snr_v;
		logic [15:0] noise_v;
		logic [1:0]  err;
		logic        last;
	} frame_result_t;

	parse_phase_t  phase;
	logic [63:0]   magic_window;
	logic [31:0]   byte_count;
	logic [31:0]   acc_word;
	logic [31:0]   pkt_len;
	logic [15:0]   obj_total;
	logic [15:0]   obj_count;
	logic [31:0]   tlv_type;
	logic [31:0]   tlv_len;
	logic          in_second;
	logic [31:0]   words [4];
	logic [7:0]    max_sub;

	frame_result_t frame_results_q[$];
	int            mismatches;
	int            n_bytes;
	int            n_points;
	int            n_records;
	int            n_rejects;

	task automatic go_hunt();
		phase = P_HUNT;
		magic_window = '0;
		byte_count = '0;
	endtask

	task automatic open_tlv_head(input logic second);
		phase = P_TLV_HEAD;
		in_second = second;
		byte_count = '0;
		acc_word = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, output bit produced,
			output frame_result_t res);
		logic [31:0] pos;
		logic [31:0] cnt;
		logic [31:0] sub;
		logic [31:0] nxt;
		logic [1:0]  err;
		produced = 1'b0;
		res = '0;
		pos = byte_count;
		case (phase)
			P_HEADER: begin
				if (pos < HDR_STORE_BYTES)
					acc_word = {b, acc_word[31:8]};
				if (pos == PKT_LEN_POS)
					pkt_len = acc_word;
				if (pos == COUNT_POS)
					words[0] = acc_word;
				byte_count = pos + 32'd1;
				if (pos + 32'd1 >= HEADER_BYTES) begin
					cnt = words[0];
					sub = acc_word;
					err = ERR_NONE;
					if (cnt == '0 || cnt[31])
						err = ERR_COUNT;
					else if (!sub[31] && sub > {24'd0, max_sub})
						err = ERR_SUBFRAME;
					else if (cnt > 32'h0000_FFFF)
						err = ERR_TOO_MANY;
					if (err != ERR_NONE) begin
						go_hunt();
						produced = 1'b1;
						res.kind = KIND_REJECT;
						res.err = err;
						res.last = 1'b1;
					end else begin
						obj_total = cnt[15:0];
						open_tlv_head(1'b0);
					end
				end
			end
			P_TLV_HEAD: begin
				acc_word = {b, acc_word[31:8]};
				if (pos == TLV_KIND_POS)
					tlv_type = acc_word;
				byte_count = pos + 32'd1;
				if (pos >= TLV_HEAD_LAST) begin
					tlv_len = acc_word;
					byte_count = '0;
					obj_count = '0;
					acc_word = '0;
					if (!in_second) begin
						if (tlv_type == TLV_POINTS && tlv_len < pkt_len)
							phase = P_POINTS;
						else if (tlv_len == '0)
							open_tlv_head(1'b1);
						else
							phase = P_SKIP;
					end else if (tlv_type == TLV_SNR) begin
						phase = P_SNR;
					end else begin
						go_hunt();
					end
				end
			end
			P_POINTS: begin
				acc_word = {b, acc_word[31:8]};
				if (pos[1:0] == 2'd3)
					words[pos[3:2]] = acc_word;
				if (pos[3:0] == 4'd15) begin
					nxt = {16'd0, obj_count} + 32'd1;
					produced = 1'b1;
					res.kind = KIND_POINT;
					res.index = obj_count;
					res.x_w = words[0];
					res.y_w = words[1];
					res.z_w = words[2];
					res.v_w = acc_word;
					res.last = (nxt == {16'd0, obj_total});
					obj_count = nxt[15:0];
				end
				byte_count = pos + 32'd1;
				if (produced && obj_count == obj_total) begin
					if (byte_count >= tlv_len)
						open_tlv_head(1'b1);
					else
						phase = P_SKIP;
				end
			end
			P_SKIP: begin
				byte_count = pos + 32'd1;
				if (byte_count >= tlv_len)
					open_tlv_head(1'b1);
			end
			P_SNR: begin
				acc_word = {b, acc_word[31:8]};
				byte_count = pos + 32'd1;
				if (pos[1:0] == 2'd3) begin
					nxt = {16'd0, obj_count} + 32'd1;
					produced = 1'b1;
					res.kind = KIND_SNR;
					res.index = obj_count;
					res.snr_v = acc_word[15:0];
					res.noise_v = acc_word[31:16];
					res.last = (nxt == {16'd0, obj_total});
					obj_count = nxt[15:0];
					if (res.last)
						go_hunt();
				end
			end
			default: begin
				magic_window = {magic_window[55:0], b};
				if (magic_window == MAGIC_WORD) begin
					phase = P_HEADER;
					byte_count = MAGIC_BYTES;
					acc_word = '0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		frame_result_t fresh;
		bit            produced;
		if (!arst_n) begin
			phase = P_HUNT;
			magic_window = '0;
			byte_count = '0;
			acc_word = '0;
			pkt_len = '0;
			obj_total = '0;
			obj_count = '0;
			tlv_type = '0;
			tlv_len = '0;
			in_second = 1'b0;
			for (int i = 0; i < 4; i++)
				words[i] = '0;
			max_sub = MAX_SUBFRAME_RESET;
			frame_results_q.delete();
			mismatches = 0;
			n_bytes = 0;
			n_points = 0;
			n_records = 0;
			n_rejects = 0;
		end else begin
			if (cfg_we)
				max_sub = cfg_data;
			if (pop && !empty) begin
				got = {kind, object_index, x_word, y_word, z_word, v_word, snr, noise,
					error_code, last};
				if (frame_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected: kind %0d index %0d",
							$time, kind, object_index);
				end else begin
					want = frame_results_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected kind %0d idx %0d x %h y %h z %h v %h snr %h noise %h err %0d last %0d",
								$time, want.kind, want.index, want.x_w, want.y_w, want.z_w,
								want.v_w, want.snr_v, want.noise_v, want.err, want.last);
							$display("%0t: actual   kind %0d idx %0d x %h y %h z %h v %h snr %h noise %h err %0d last %0d",
								$time, got.kind, got.index, got.x_w, got.y_w, got.z_w,
								got.v_w, got.snr_v, got.noise_v, got.err, got.last);
						end
					end
					if (want.kind == KIND_POINT)
						n_points++;
					else if (want.kind == KIND_SNR)
						n_records++;
					else
						n_rejects++;
				end
			end
			if (push && !full) begin
				n_bytes++;
				parse_byte(data_byte, produced, fresh);
				if (produced)
					frame_results_q.push_back(fresh);
			end
		end
		fail_count <= mismatches;
		outstanding <= frame_results_q.size();
		byte_total <= n_bytes;
		point_total <= n_points;
		record_total <= n_records;
		reject_total <= n_rejects;
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// top of the radar tlv frame parser testbench: clock, reset, byte stream and pop stimulus
// depends on rtfp_pkg, radar_tlv_frame_parser and tlv_result_checker
module testbench import rtfp_pkg::*;;

	localparam int HEADER_BYTES = 40;
	localparam int QUIET_LIMIT = 4000;
	localparam int IDLE_NONE = 0;
	localparam int IDLE_TX = 1;
	localparam int IDLE_RX = 2;
	localparam int IDLE_BOTH = 3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        cfg_we;
	logic [7:0]  cfg_data;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [15:0] object_index;
	logic [31:0] x_word;
	logic [31:0] y_word;
	logic [31:0] z_word;
	logic [31:0] v_word;
	logic [15:0] snr;
	logic [15:0] noise;
	logic [1:0]  error_code;
	logic        last;

	int          fail_count;
	int          outstanding;
	int          byte_total;
	int          point_total;
	int          record_total;
	int          reject_total;

	logic [7:0]  stream_q[$];
	int          planned_results;
	logic [7:0]  cur_max_sub;
	bit          rx_run;

	always #4 clk = ~clk;

	radar_tlv_frame_parser #(.HEADER_BYTES(HEADER_BYTES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.object_index(object_index),
		.x_word(x_word),
		.y_word(y_word),
		.z_word(z_word),
		.v_word(v_word),
		.snr(snr),
		.noise(noise),
		.error_code(error_code),
		.last(last)
	);

	tlv_result_checker #(.HEADER_BYTES(HEADER_BYTES)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.object_index(object_index),
		.x_word(x_word),
		.y_word(y_word),
		.z_word(z_word),
		.v_word(v_word),
		.snr(snr),
		.noise(noise),
		.error_code(error_code),
		.last(last),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.byte_total(byte_total),
		.point_total(point_total),
		.record_total(record_total),
		.reject_total(reject_total)
	);

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			stream_q.push_back(w[8*i +: 8]);
	endtask

	task automatic put_magic_prefix(input int n);
		for (int i = 0; i < n; i++)
			stream_q.push_back(MAGIC_WORD[63 - 8*i -: 8]);
	endtask

	task automatic put_frame(input logic [31:0] count, input logic [31:0] sub,
			input logic [31:0] t1_kind, input logic [31:0] t1_len,
			input logic [31:0] pkt_len, input logic [31:0] t2_kind);
		logic [31:0] body;
		bit          rejected;
		rejected = count == '0 || count[31] || (!sub[31] && sub > {24'd0, cur_max_sub})
			|| count > 32'h0000_FFFF;
		put_magic_prefix(8);
		put_word($urandom);
		put_word(pkt_len);
		repeat (3) put_word($urandom);
		put_word(count);
		put_word($urandom);
		put_word(sub);
		if (rejected) begin
			planned_results++;
		end else begin
			put_word(t1_kind);
			put_word(t1_len);
			if (t1_kind == TLV_POINTS && t1_len < pkt_len) begin
				body = count * 16;
				if (t1_len > body)
					body = t1_len;
				planned_results += count;
			end else begin
				body = t1_len;
			end
			repeat (body) stream_q.push_back(8'($urandom_range(0, 255)));
			put_word(t2_kind);
			put_word($urandom_range(0, 64));
			if (t2_kind == TLV_SNR) begin
				repeat (4 * count) stream_q.push_back(8'($urandom_range(0, 255)));
				planned_results += count;
			end
		end
	endtask

	task automatic put_random_frame();
		logic [31:0] count;
		logic [31:0] sub;
		logic [31:0] t1_kind;
		logic [31:0] t1_len;
		logic [31:0] pkt_len;
		logic [31:0] t2_kind;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			count = '0;
		else if (roll < 7)
			count = 32'h8000_0000 | $urandom;
		else if (roll < 10)
			count = 32'h0001_0000 + $urandom_range(0, 32'h00FF_FFFF);
		else
			count = $urandom_range(1, 4);
		roll = $urandom_range(0, 99);
		if (roll < 8)
			sub = $urandom;
		else if (roll < 12)
			sub = {24'd0, cur_max_sub} + 32'd1;
		else
			sub = $urandom_range(0, cur_max_sub);
		t1_kind = ($urandom_range(0, 99) < 80) ? TLV_POINTS : 32'($urandom_range(0, 9));
		if ($urandom_range(0, 99) < 15)
			t1_len = $urandom_range(0, count * 16);
		else
			t1_len = count * 16 + $urandom_range(0, 6);
		if ($urandom_range(0, 99) < 85)
			pkt_len = t1_len + $urandom_range(1, 3000);
		else
			pkt_len = $urandom_range(0, t1_len);
		t2_kind = ($urandom_range(0, 99) < 85) ? TLV_SNR : 32'($urandom_range(0, 15));
		put_frame(count, sub, t1_kind, t1_len, pkt_len, t2_kind);
	endtask

	// mostly whole frames, with noise bursts and cut-off magic words in between
	task automatic build_random(input int min_bytes, input int min_results);
		int roll;
		while (stream_q.size() < min_bytes || planned_results < min_results) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				repeat ($urandom_range(1, 12))
					stream_q.push_back(8'($urandom_range(0, 255)));
			end else if (roll < 24) begin
				put_magic_prefix($urandom_range(1, 7));
				put_random_frame();
			end else begin
				put_random_frame();
			end
		end
	endtask

	task automatic write_max_sub(input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_max_sub = value;
	endtask

	task automatic send_stream(input int idle_pct);
		int sent;
		sent = 0;
		while (sent < stream_q.size()) begin
			if ($urandom_range(0, 99) < idle_pct) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				data_byte <= stream_q[sent];
			end
			@(posedge clk);
			if (push && !full)
				sent++;
		end
		push <= 1'b0;
		stream_q.delete();
	endtask

	task automatic run_phase(input int mode, input int hold);
		int tx_idle;
		int rx_stall;
		tx_idle = (mode == IDLE_TX) ? 83 : (mode == IDLE_BOTH) ? 7 : 0;
		rx_stall = (mode == IDLE_RX) ? 83 : (mode == IDLE_BOTH) ? 7 : 0;
		rx_run = 1'b1;
		fork
			begin
				send_stream(tx_idle);
				do
					@(posedge clk);
				while (outstanding != 0);
				rx_run = 1'b0;
			end
			begin
				// long hold-off so the result queue fills and full backs up the bytes
				repeat (hold) @(posedge clk);
				while (rx_run) begin
					pop <= ($urandom_range(0, 99) >= rx_stall);
					@(posedge clk);
				end
				pop <= 1'b0;
			end
		join
		repeat (4) @(posedge clk);
		planned_results = 0;
	endtask

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		planned_results = 0;
		cur_max_sub = MAX_SUBFRAME_RESET;
		rx_run = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_max_sub(MAX_SUBFRAME_RESET);
		put_frame(32'd2, 32'd3, TLV_POINTS, 32'd32, 32'd1000, TLV_SNR);
		put_frame(32'd0, 32'd200, TLV_POINTS, 32'd16, 32'd1000, TLV_SNR);
		put_frame(32'h0001_0000, 32'd0, TLV_POINTS, 32'd16, 32'd1000, TLV_SNR);
		put_frame(32'd1, 32'h8000_0005, TLV_POINTS, 32'd20, 32'd20, TLV_SNR);
		run_phase(IDLE_NONE, 0);

		write_max_sub(8'd0);
		put_frame(32'h8000_0000, 32'd0, TLV_POINTS, 32'd16, 32'd1000, TLV_SNR);
		put_frame(32'd1, 32'd1, TLV_POINTS, 32'd16, 32'd100, TLV_SNR);
		put_frame(32'd2, 32'd0, 32'd5, 32'd0, 32'd1000, 32'd3);
		run_phase(IDLE_TX, 0);

		write_max_sub(8'd255);
		put_frame(32'd2, 32'd255, TLV_POINTS, 32'd10, 32'd100, TLV_SNR);
		put_frame(32'h0001_0000, 32'd256, TLV_POINTS, 32'd16, 32'd100, TLV_SNR);
		run_phase(IDLE_RX, 0);

		write_max_sub(8'($urandom_range(0, 255)));
		build_random(60, 2);
		run_phase(IDLE_BOTH, 0);

		write_max_sub(MAX_SUBFRAME_RESET);
		put_magic_prefix(7);
		stream_q.push_back(8'h00);
		put_frame(32'd1, 32'd3, TLV_POINTS, 32'd18, 32'hFFFF_FFFF, TLV_SNR);
		put_frame(32'd4, 32'd2, TLV_POINTS, 32'd64, 32'd5000, TLV_SNR);
		run_phase(IDLE_NONE, 300);

		$display("run covered %0d bytes giving %0d points, %0d snr records, %0d rejections",
			byte_total, point_total, record_total, reject_total);
		$display("five phases, subframe limits 0, 3, 255 and random, gaps, stalls, backpressure");
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rtfp_pkg.sv
hw/rtl/rtfp_front.sv
hw/rtl/rtfp_queue.sv
hw/rtl/rtfp_back.sv
hw/rtl/radar_tlv_frame_parser.sv
dv/tlv_result_checker.sv
dv/testbench.sv
